// File: rtl/bdq_pkg.sv
package bdq_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 3;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_SEARCH     = 3'd4;
  localparam logic [FUNC_W-1:0] FN_READ_POS   = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_READ,
    S_RESULT
  } state_t;

endpackage

// File: rtl/bdq_if.sv
interface bdq_cmd_if #(
  parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
);
  localparam int ADDR_W = $clog2(DEPTH);

  logic                         valid;
  logic                         ready;
  logic [bdq_pkg::FUNC_W-1:0]   func;
  logic signed [DATA_WIDTH-1:0] value;
  logic [ADDR_W-1:0]            position;

  modport source (output valid, func, value, position, input ready);
  modport sink   (input valid, func, value, position, output ready);
endinterface

interface bdq_rsp_if #(
  parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
);
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int COUNT_W = $clog2(DEPTH + 1);

  logic                         valid;
  logic                         ready;
  logic [bdq_pkg::STATUS_W-1:0] status;
  logic signed [DATA_WIDTH-1:0] read_value;
  logic [ADDR_W-1:0]            match_index;
  logic [COUNT_W-1:0]           occupancy;
  logic                         is_empty;

  modport source (output valid, status, read_value, match_index, occupancy, is_empty,
                  input ready);
  modport sink   (input valid, status, read_value, match_index, occupancy, is_empty,
                  output ready);
endinterface

// File: rtl/bdq_ram.sv
module bdq_ram #(
  parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF,
  parameter int ADDR_W     = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ADDR_W-1:0]     addr,
  input  logic [DATA_WIDTH-1:0] wdata,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  // Single port, read-before-write, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/bdq_ctrl.sv
module bdq_ctrl #(
  parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF,
  parameter int ADDR_W     = $clog2(DEPTH),
  parameter int COUNT_W    = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  bdq_cmd_if.sink               cmd,
  bdq_rsp_if.source             rsp,
  output logic                  mem_we,
  output logic [ADDR_W-1:0]     mem_addr,
  output logic [DATA_WIDTH-1:0] mem_wdata,
  input  logic [DATA_WIDTH-1:0] mem_rdata
);

  import bdq_pkg::*;

  localparam logic [ADDR_W:0]    DEPTH_A = (ADDR_W + 1)'(DEPTH);
  localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(DEPTH);

  // Ring index arithmetic: both operands below DEPTH, so one subtract wraps
  function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
                                                 input logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_A) begin
      s = s - DEPTH_A;
    end
    return s[ADDR_W-1:0];
  endfunction

  state_t state, state_next;

  logic [ADDR_W-1:0]     front_ptr, front_ptr_next;
  logic [COUNT_W-1:0]    count, count_next;

  logic [FUNC_W-1:0]     op_func;
  logic [DATA_WIDTH-1:0] op_value;
  logic [ADDR_W-1:0]     op_pos;

  logic [ADDR_W-1:0]     scan_idx, scan_idx_next;
  logic [ADDR_W-1:0]     scan_addr, scan_addr_next;

  logic [STATUS_W-1:0]   res_status, res_status_next;
  logic [DATA_WIDTH-1:0] res_value, res_value_next;
  logic [ADDR_W-1:0]     res_idx, res_idx_next;

  logic                  rsp_valid;
  logic [STATUS_W-1:0]   rsp_status;
  logic [DATA_WIDTH-1:0] rsp_value;
  logic [ADDR_W-1:0]     rsp_idx;
  logic [COUNT_W-1:0]    rsp_count;

  logic cmd_fire, out_free, is_full, is_zero, scan_hit, scan_last, pos_bad;

  assign cmd_fire  = cmd.valid && cmd.ready;
  assign out_free  = !rsp_valid || rsp.ready;
  assign is_full   = (count == DEPTH_C);
  assign is_zero   = (count == '0);
  assign scan_hit  = (mem_rdata == op_value);
  assign scan_last = ((COUNT_W'(scan_idx) + COUNT_W'(1)) == count);
  assign pos_bad   = (COUNT_W'(op_pos) >= count);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_RESULT;
        if (op_func == FN_SEARCH && !is_zero) begin
          state_next = S_SCAN;
        end else if (op_func == FN_READ_POS && !is_zero && !pos_bad) begin
          state_next = S_READ;
        end
      end
      S_SCAN: begin
        if (scan_hit || scan_last) begin
          state_next = S_RESULT;
        end
      end
      S_READ: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath controls and memory port
  always_comb begin
    cmd.ready       = (state == S_IDLE);
    mem_we          = 1'b0;
    mem_addr        = front_ptr;
    mem_wdata       = op_value;
    front_ptr_next  = front_ptr;
    count_next      = count;
    scan_idx_next   = scan_idx;
    scan_addr_next  = scan_addr;
    res_status_next = res_status;
    res_value_next  = res_value;
    res_idx_next    = res_idx;

    unique case (state)
      S_IDLE: begin
      end
      S_DISPATCH: begin
        res_status_next = ST_OK;
        res_value_next  = '0;
        res_idx_next    = '0;
        case (op_func) inside
          FN_PUSH_FRONT, FN_PUSH_BACK: begin
            if (is_full) begin
              res_status_next = ST_FULL;
            end else begin
              mem_we     = 1'b1;
              count_next = count + COUNT_W'(1);
              if (op_func == FN_PUSH_FRONT) begin
                front_ptr_next = wrap_add(front_ptr, ADDR_W'(DEPTH - 1));
                mem_addr       = front_ptr_next;
              end else begin
                mem_addr = wrap_add(front_ptr, count[ADDR_W-1:0]);
              end
            end
          end
          FN_POP_FRONT, FN_POP_BACK: begin
            if (is_zero) begin
              res_status_next = ST_EMPTY;
            end else begin
              count_next = count - COUNT_W'(1);
              if (op_func == FN_POP_FRONT) begin
                front_ptr_next = wrap_add(front_ptr, ADDR_W'(1));
              end
            end
          end
          FN_SEARCH: begin
            if (is_zero) begin
              res_status_next = ST_EMPTY;
            end else begin
              // Fetch the front element; queue up the next slot
              mem_addr       = front_ptr;
              scan_idx_next  = '0;
              scan_addr_next = wrap_add(front_ptr, ADDR_W'(1));
            end
          end
          FN_READ_POS: begin
            if (is_zero) begin
              res_status_next = ST_EMPTY;
            end else if (pos_bad) begin
              res_status_next = ST_RANGE;
            end else begin
              mem_addr = wrap_add(front_ptr, op_pos);
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        if (scan_hit) begin
          res_value_next = op_value;
          res_idx_next   = scan_idx;
        end else if (scan_last) begin
          res_status_next = ST_NOT_FOUND;
        end else begin
          mem_addr       = scan_addr;
          scan_idx_next  = scan_idx + ADDR_W'(1);
          scan_addr_next = wrap_add(scan_addr, ADDR_W'(1));
        end
      end
      S_READ: begin
        res_value_next = mem_rdata;
      end
      S_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front_ptr <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      front_ptr <= front_ptr_next;
      count     <= count_next;
      if (state == S_RESULT && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      op_func  <= cmd.func;
      op_value <= cmd.value;
      op_pos   <= cmd.position;
    end
    scan_idx   <= scan_idx_next;
    scan_addr  <= scan_addr_next;
    res_status <= res_status_next;
    res_value  <= res_value_next;
    res_idx    <= res_idx_next;
    if (state == S_RESULT && out_free) begin
      rsp_status <= res_status;
      rsp_value  <= res_value;
      rsp_idx    <= res_idx;
      rsp_count  <= count;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.read_value  = rsp_value;
  assign rsp.match_index = rsp_idx;
  assign rsp.occupancy   = rsp_count;
  assign rsp.is_empty    = (rsp_count == '0);

endmodule

// File: rtl/bounded_deque_with_search_unit.sv
// Bounded double-ended queue of signed values kept in a single-port ring memory.
// Each command transaction on cmd carries one operation (push front, push back,
// pop front, pop back, search for a value, read at a position from the front)
// and yields exactly one response transaction on rsp with a status, the value
// read or matched, the index of the first match, the occupancy after the
// operation and an empty flag. Commands are handled one at a time: push, pop and
// rejected operations pass through the dispatch and result states, a positional
// read adds a read state, and a search adds a scan state that compares up to
// the occupancy (at most DEPTH) elements, walking the ring one memory read per
// cycle through the single memory port. A finished response sits in an output
// register, so the next command is taken while the previous response still
// waits for rsp.ready. No clearing pass is needed after reset: only slots that
// hold pushed elements are ever read.
module bounded_deque_with_search_unit #(
  parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  bdq_cmd_if.sink   cmd,
  bdq_rsp_if.source rsp
);

  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int COUNT_W = $clog2(DEPTH + 1);

  // Memory port between the sequencer and the ring storage
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_addr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [DATA_WIDTH-1:0] mem_rdata;

  // Sequencer: holds the front pointer and count, decodes the command,
  // drives the ring memory and owns the response register.
  bdq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .ADDR_W     (ADDR_W),
    .COUNT_W    (COUNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  // Ring storage: one element per slot, read data registered and valid in the next cycle.
  bdq_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .ADDR_W     (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

// File: rtl/bdq_checker.sv
module bdq_checker #(
  parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF,
  parameter int ADDR_W     = $clog2(DEPTH),
  parameter int COUNT_W    = $clog2(DEPTH + 1)
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         cmd_valid,
  input logic                         cmd_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [bdq_pkg::STATUS_W-1:0] rsp_status,
  input logic [DATA_WIDTH-1:0]        rsp_read_value,
  input logic [ADDR_W-1:0]            rsp_match_index,
  input logic [COUNT_W-1:0]           rsp_occupancy,
  input logic                         rsp_is_empty
);

  import bdq_pkg::*;

  localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(DEPTH);

  // Hold the response while it is stalled
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=>
      rsp_valid && $stable(rsp_status) && $stable(rsp_read_value) &&
      $stable(rsp_match_index) && $stable(rsp_occupancy))
    else $error("response changed while stalled");

  // One command at a time: ready drops right after a transaction
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken in back-to-back cycles");

  // Occupancy and empty flag agree and stay in bounds
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_occupancy <= DEPTH_C) && (rsp_is_empty == (rsp_occupancy == '0)))
    else $error("occupancy out of bounds or empty flag mismatch");

  // Full only at capacity, empty only with nothing held
  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_EMPTY) |->
      (rsp_status == ST_FULL) ? (rsp_occupancy == DEPTH_C) : rsp_is_empty)
    else $error("full or empty status with wrong occupancy");

endmodule

bind bounded_deque_with_search_unit bdq_checker #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH)
) u_bdq_checker (
  .clk             (clk),
  .rst             (rst),
  .cmd_valid       (cmd.valid),
  .cmd_ready       (cmd.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_read_value  (rsp.read_value),
  .rsp_match_index (rsp.match_index),
  .rsp_occupancy   (rsp.occupancy),
  .rsp_is_empty    (rsp.is_empty)
);

// File: tb/bounded_deque_with_search_unit_tb.sv
`timescale 1ns / 1ps

// Checks the bounded deque unit. Every accepted command runs through a
// behavioral copy of the deque (front index, count, ring of slots). The copy's
// response, or the one a typed row gives, is queued. Each response the unit
// hands back is compared field by field with the oldest queued one. A short
// table of directed commands comes first. Then come random commands, grouped
// in fill, drain and mixed phases so the ring fills and empties many times.
module bounded_deque_with_search_unit_tb;
  import bdq_pkg::*;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int N_RANDOM   = 850;
  localparam int N_QUIET    = 120;   // tail of the run with no idling
  localparam int HOLD_AT    = 200;   // command count that triggers the long stall
  localparam int HOLD_LEN   = 400;   // cycles of the long stall
  localparam int DRAIN_WAIT = 100;   // wait after the last response for stray ones

  // Operation codes with no defined operation
  localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic signed [31:0] value;
    logic [5:0]         position;
  } deque_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic signed [31:0]  read_value;
    logic [5:0]          match_index;
    logic [6:0]          occupancy;
    logic                is_empty;
  } deque_result_t;

  typedef struct {
    deque_op_t     op;
    bit            typed;   // expected response written out in the row
    deque_result_t res;
  } stim_row_t;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIX} phase_t;

  logic clk;
  logic rst;

  bdq_cmd_if cmd_bus ();
  bdq_rsp_if rsp_bus ();

  bounded_deque_with_search_unit u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .rsp (rsp_bus)
  );

  // Predicted deque contents: ring of slots, front index and element count.
  logic signed [31:0] ring_slots [DEPTH];
  logic [5:0]         ring_head;
  logic [6:0]         ring_count;

  deque_result_t pending_results [$];
  stim_row_t     directed_rows [$];

  int     errors     = 0;
  int     sent_count = 0;
  bit     quiet      = 1'b0;
  bit     held_off   = 1'b0;
  phase_t phase      = PH_FILL;
  int     phase_left = 3;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Apply one command to the predicted deque and work out its response.
  function automatic void deque_apply(input deque_op_t op, output deque_result_t res);
    int         i;
    logic [5:0] slot;
    res = '0;
    case (op.func)
      FN_PUSH_FRONT, FN_PUSH_BACK: begin
        if (ring_count == DEPTH) begin
          res.status = ST_FULL;
        end else if (op.func == FN_PUSH_FRONT) begin
          ring_head = ring_head - 6'd1;  // wraps at the ring boundary
          ring_slots[ring_head] = op.value;
          ring_count++;
        end else begin
          slot = ring_head + ring_count[5:0];
          ring_slots[slot] = op.value;
          ring_count++;
        end
      end
      FN_POP_FRONT, FN_POP_BACK: begin
        if (ring_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          if (op.func == FN_POP_FRONT) ring_head = ring_head + 6'd1;
          ring_count--;
        end
      end
      FN_SEARCH: begin
        if (ring_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // Walk from the front; the first match wins, the last slot included.
          res.status = ST_NOT_FOUND;
          for (i = 0; i < ring_count; i++) begin
            slot = ring_head + i[5:0];
            if (ring_slots[slot] == op.value) begin
              res.status      = ST_OK;
              res.read_value  = op.value;
              res.match_index = i[5:0];
              break;
            end
          end
        end
      end
      FN_READ_POS: begin
        if (ring_count == 0) begin
          res.status = ST_EMPTY;
        end else if (op.position >= ring_count) begin
          res.status = ST_RANGE;
        end else begin
          slot = ring_head + op.position;
          res.read_value = ring_slots[slot];
        end
      end
      default: ;  // unused codes leave the deque alone and report ok
    endcase
    res.occupancy = ring_count;
    res.is_empty  = (ring_count == 0);
  endfunction

  // Mix extremes and a narrow band of small values in with full-range
  // ones, so searches run into duplicates and first-match ordering matters.
  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFFFFFF;
      1:       return 32'sh80000000;
      2, 3, 4: return $signed($urandom_range(0, 16)) - 32'sd8;
      default: return $urandom;
    endcase
  endfunction

  // Pick the next random command from the current phase and the predicted
  // contents. Fill and drain phases hold at the bound for a few extra
  // commands so the full and empty responses come up often.
  function automatic deque_op_t pick_op();
    deque_op_t op;
    int        roll;
    int        pick;
    logic [5:0] slot;
    case (phase)
      PH_FILL: begin
        if (ring_count == DEPTH) begin
          if (phase_left == 0) begin
            phase = PH_MIX; phase_left = $urandom_range(30, 80);
          end else begin
            phase_left--;
          end
        end
      end
      PH_DRAIN: begin
        if (ring_count == 0) begin
          if (phase_left == 0) begin
            phase = PH_MIX; phase_left = $urandom_range(30, 80);
          end else begin
            phase_left--;
          end
        end
      end
      default: begin
        if (phase_left == 0) begin
          phase      = (ring_count < DEPTH / 2) ? PH_FILL : PH_DRAIN;
          phase_left = $urandom_range(2, 5);
        end else begin
          phase_left--;
        end
      end
    endcase

    roll = $urandom_range(0, 99);
    case (phase)
      PH_FILL:  pick = (roll < 80) ? 0 : (roll < 88) ? 2 : (roll < 96) ? 3 : (roll < 98) ? 1 : 4;
      PH_DRAIN: pick = (roll < 75) ? 1 : (roll < 85) ? 2 : (roll < 95) ? 3 : (roll < 97) ? 0 : 4;
      default:  pick = (roll < 24) ? 0 : (roll < 48) ? 1 : (roll < 72) ? 2 : (roll < 97) ? 3 : 4;
    endcase

    op.value    = rand_value();
    op.position = 6'($urandom_range(0, 63));
    case (pick)
      0: op.func = $urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_BACK;
      1: op.func = $urandom_range(0, 1) ? FN_POP_FRONT : FN_POP_BACK;
      2: begin
        op.func = FN_SEARCH;
        // Mostly look for a held value so hits land across the whole ring.
        if (ring_count != 0 && $urandom_range(0, 9) < 6) begin
          slot     = ring_head + 6'($urandom_range(0, ring_count - 1));
          op.value = ring_slots[slot];
        end
      end
      3: begin
        op.func = FN_READ_POS;
        if (ring_count != 0 && $urandom_range(0, 3) != 0)
          op.position = 6'($urandom_range(0, ring_count - 1));
      end
      default: op.func = $urandom_range(0, 1) ? FN_UNUSED_LO : FN_UNUSED_HI;
    endcase
    return op;
  endfunction

  task automatic add_row(input logic [FUNC_W-1:0] func, input logic signed [31:0] value,
                         input logic [5:0] position, input bit typed,
                         input logic [STATUS_W-1:0] status, input logic signed [31:0] rd,
                         input logic [5:0] idx, input logic [6:0] occ, input logic emp);
    stim_row_t row;
    row.op    = '{func: func, value: value, position: position};
    row.typed = typed;
    row.res   = '{status: status, read_value: rd, match_index: idx,
                  occupancy: occ, is_empty: emp};
    directed_rows.push_back(row);
  endtask

  // Offer one command, wait for the handshake, then record its expectation.
  task automatic send_op(input deque_op_t op, input bit typed, input deque_result_t res);
    deque_result_t want;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      cmd_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    cmd_bus.valid    <= 1'b1;
    cmd_bus.func     <= op.func;
    cmd_bus.value    <= op.value;
    cmd_bus.position <= op.position;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    // Always advance the predicted deque; a typed row only overrides the
    // expected response.
    deque_apply(op, want);
    pending_results.push_back(typed ? res : want);
    sent_count++;
  endtask

  // Command side: reset, directed table, random phases, drain and verdict.
  initial begin : cmd_source
    int            n;
    deque_op_t     op;
    deque_result_t none;

    rst              = 1'b1;
    cmd_bus.valid    = 1'b0;
    cmd_bus.func     = FN_PUSH_FRONT;
    cmd_bus.value    = '0;
    cmd_bus.position = '0;
    ring_head        = '0;
    ring_count       = '0;
    none             = '0;
    foreach (ring_slots[i]) ring_slots[i] = '0;

    //       func           value          pos  typ status        read_value     idx occ emp
    add_row(FN_POP_FRONT,  32'sd0,         0,  1, ST_EMPTY,     32'sd0,         0, 0, 1);
    add_row(FN_POP_BACK,   32'sd0,         0,  1, ST_EMPTY,     32'sd0,         0, 0, 1);
    add_row(FN_SEARCH,     32'sd5,         0,  1, ST_EMPTY,     32'sd0,         0, 0, 1);
    add_row(FN_READ_POS,   32'sd0,         0,  1, ST_EMPTY,     32'sd0,         0, 0, 1);
    add_row(FN_UNUSED_LO,  32'sd9,         9,  1, ST_OK,        32'sd0,         0, 0, 1);
    add_row(FN_PUSH_BACK,  32'sh7FFFFFFF,  0,  1, ST_OK,        32'sd0,         0, 1, 0);
    add_row(FN_PUSH_FRONT, 32'sh80000000,  0,  1, ST_OK,        32'sd0,         0, 2, 0);
    add_row(FN_PUSH_BACK,  32'sd0,         0,  1, ST_OK,        32'sd0,         0, 3, 0);
    add_row(FN_PUSH_BACK,  -32'sd1,        0,  1, ST_OK,        32'sd0,         0, 4, 0);
    add_row(FN_READ_POS,   32'sd0,         0,  1, ST_OK,        32'sh80000000,  0, 4, 0);
    add_row(FN_READ_POS,   32'sd0,         3,  1, ST_OK,        -32'sd1,        0, 4, 0);
    add_row(FN_READ_POS,   32'sd0,         4,  1, ST_RANGE,     32'sd0,         0, 4, 0);
    add_row(FN_READ_POS,   32'sd0,        63,  1, ST_RANGE,     32'sd0,         0, 4, 0);
    add_row(FN_SEARCH,     -32'sd1,        0,  1, ST_OK,        -32'sd1,        3, 4, 0);
    add_row(FN_SEARCH,     32'sh7FFFFFFF,  0,  1, ST_OK,        32'sh7FFFFFFF,  1, 4, 0);
    add_row(FN_SEARCH,     32'sh80000000,  0,  1, ST_OK,        32'sh80000000,  0, 4, 0);
    add_row(FN_SEARCH,     32'sd12345,     0,  1, ST_NOT_FOUND, 32'sd0,         0, 4, 0);
    add_row(FN_UNUSED_HI,  -32'sd1,       63,  1, ST_OK,        32'sd0,         0, 4, 0);
    // Duplicate zero at the front: the search must report the front one.
    add_row(FN_PUSH_FRONT, 32'sd0,         0,  0, ST_OK,        32'sd0,         0, 0, 0);
    add_row(FN_SEARCH,     32'sd0,         0,  0, ST_OK,        32'sd0,         0, 0, 0);
    add_row(FN_POP_BACK,   32'sd0,         0,  1, ST_OK,        32'sd0,         0, 4, 0);
    add_row(FN_POP_FRONT,  32'sd0,         0,  1, ST_OK,        32'sd0,         0, 3, 0);
    add_row(FN_POP_FRONT,  32'sd0,         0,  1, ST_OK,        32'sd0,         0, 2, 0);
    add_row(FN_POP_BACK,   32'sd0,         0,  1, ST_OK,        32'sd0,         0, 1, 0);
    add_row(FN_POP_FRONT,  32'sd0,         0,  1, ST_OK,        32'sd0,         0, 0, 1);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_op(directed_rows[i].op, directed_rows[i].typed, directed_rows[i].res);

    for (n = 0; n < N_RANDOM; n++) begin
      quiet = (n >= N_RANDOM - N_QUIET);
      op = pick_op();
      send_op(op, 1'b0, none);
    end
    cmd_bus.valid <= 1'b0;

    // Hold until every response is back, then give stray ones time to show.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Response side: random stalls, one long hold-off that backs the unit up
  // into its command port, and steady ready in the quiet tail.
  initial begin : rsp_sink
    rsp_bus.ready = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (!held_off && sent_count >= HOLD_AT) begin
        held_off = 1'b1;
        rsp_bus.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        rsp_bus.ready <= 1'b1;
        repeat (quiet ? 1 : $urandom_range(1, 24)) @(posedge clk);
      end else begin
        rsp_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // Compare each response transaction with the oldest expectation.
  deque_result_t oldest;
  always @(posedge clk) begin
    if (!rst && rsp_bus.valid === 1'b1 && rsp_bus.ready) begin
      if (pending_results.size() == 0) begin
        $error("response with no command outstanding");
        errors++;
      end else begin
        oldest = pending_results.pop_front();
        compare_field("status",      32'(oldest.status),      32'(rsp_bus.status));
        compare_field("read_value",  oldest.read_value,       rsp_bus.read_value);
        compare_field("match_index", 32'(oldest.match_index), 32'(rsp_bus.match_index));
        compare_field("occupancy",   32'(oldest.occupancy),   32'(rsp_bus.occupancy));
        compare_field("is_empty",    32'(oldest.is_empty),    32'(rsp_bus.is_empty));
      end
    end
  end

  // Stop a hung run. Roughly 875 commands at the worst search latency plus
  // gaps and the long hold take about a millisecond.
  initial begin : watchdog
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
